FILE: design/spmv_pkg.sv
// Shared constants, register codes and interface structs of the spline velocity map.
// Used by every module of the block; depends on nothing.
package spmv_pkg;

    localparam int EPS       = 16;
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 17;
    localparam int ONE       = 65536;
    localparam int SLOPE_W   = 32;
    localparam int DEN_W     = 17;
    localparam int RCP_SH    = 33;
    localparam int RCP_W     = RCP_SH + 1 - $clog2(EPS);
    localparam int A_W       = 21;
    localparam int A_MAX     = 1 << (A_W - 1);
    localparam int IDX_W     = 3;

    localparam int MEAN_NUM_W = VAL_W + SLOPE_W + 1;
    localparam int SEC_NUM_W  = VAL_W + FRAC_BITS;
    localparam int NUM_W0     = (MEAN_NUM_W > SEC_NUM_W) ? MEAN_NUM_W : SEC_NUM_W;
    localparam int NUM_W      = (NUM_W0 > RCP_SH + 1) ? NUM_W0 : RCP_SH + 1;

    localparam logic [IDX_W-1:0] REG_P0_IN  = 3'd0;
    localparam logic [IDX_W-1:0] REG_P0_OUT = 3'd1;
    localparam logic [IDX_W-1:0] REG_P1_IN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_P1_OUT = 3'd3;
    localparam logic [IDX_W-1:0] REG_P2_IN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_P2_OUT = 3'd5;
    localparam logic [IDX_W-1:0] REG_SHELF  = 3'd6;

    typedef struct packed {
        logic [2:0][VAL_W-1:0] pin;
        logic [2:0][VAL_W-1:0] pout;
        logic                  shelf;
    } t_cfg;

    typedef struct packed {
        logic [3:0][RCP_W-1:0]   recip;
        logic [4:0][SLOPE_W-1:0] slope;
    } t_tab;

    function automatic logic [VAL_W-1:0] clamp_pt(input logic [VAL_W:0] v,
                                                  input logic [VAL_W:0] lo,
                                                  input logic [VAL_W:0] hi);
        logic [VAL_W:0] r;
        r = (v < hi) ? v : hi;
        r = (r > lo) ? r : lo;
        return r[VAL_W-1:0];
    endfunction

endpackage

FILE: design/spmv_div.sv
// Restoring divider, one quotient bit per cycle, for the slope table sequencer.
// Depends on spmv_pkg for operand widths.
module spmv_div import spmv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_work;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0] n_rem_sh;
    logic           n_ge;
    logic [DEN_W:0] n_rem;

    always_comb begin
        n_rem_sh = {r_rem, r_work[NUM_W-1]};
        n_ge     = n_rem_sh >= {1'b0, r_den};
        n_rem    = n_ge ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift the numerator out and the quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_run) begin
            r_work <= {r_work[NUM_W-2:0], n_ge};
            r_rem  <= n_rem[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_work;

endmodule

FILE: design/spmv_slopes.sv
// Knot slope and segment reciprocal table, rebuilt after configuration changes.
// Depends on spmv_pkg and spmv_div.
module spmv_slopes import spmv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cfg_wr,
    output logic o_busy,
    output t_tab o_tab
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_KICK = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [3:0] JOB_SEC0  = 4'd0;
    localparam logic [3:0] JOB_RCP0  = 4'd4;
    localparam logic [3:0] JOB_MEAN0 = 4'd8;
    localparam logic [3:0] JOB_LAST  = 4'd10;

    localparam int PROD_W = DEN_W + SLOPE_W;

    logic [2:0] r_state;
    logic [3:0] r_job;
    logic       r_stale;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [3:0][SLOPE_W-1:0] r_d;
    logic [2:0][SLOPE_W-1:0] r_mean;
    logic [3:0][RCP_W-1:0]   r_recip;
    logic [4:0][SLOPE_W-1:0] r_slope;

    logic [3:0][DEN_W-1:0] h;
    logic [3:0][DEN_W-1:0] dy;
    logic [1:0]            sel;
    logic [DEN_W-1:0]      hs, hn, dys;
    logic [SLOPE_W-1:0]    dl, dn;
    logic [PROD_W-1:0]     prod_a, prod_b;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quo;
    logic [SLOPE_W-1:0]    quo_sat;

    function automatic logic [SLOPE_W-1:0] steffen(input logic [SLOPE_W-1:0] a,
                                                   input logic [SLOPE_W-1:0] b,
                                                   input logic [SLOPE_W-1:0] mean);
        logic [SLOPE_W:0] tw;
        tw = (a < b) ? {a, 1'b0} : {b, 1'b0};
        return (tw < {1'b0, mean}) ? tw[SLOPE_W-1:0] : mean;
    endfunction

    assign h[0]  = i_cfg.pin[0];
    assign h[1]  = i_cfg.pin[1] - i_cfg.pin[0];
    assign h[2]  = i_cfg.pin[2] - i_cfg.pin[1];
    assign h[3]  = DEN_W'(ONE) - i_cfg.pin[2];
    assign dy[0] = i_cfg.pout[0];
    assign dy[1] = i_cfg.pout[1] - i_cfg.pout[0];
    assign dy[2] = i_cfg.pout[2] - i_cfg.pout[1];
    assign dy[3] = DEN_W'(ONE) - i_cfg.pout[2];

    assign sel = r_job[1:0];

    always_comb begin
        unique case (sel)
            2'd0: begin hs = h[0]; dys = dy[0]; hn = h[1]; dl = r_d[0]; dn = r_d[1]; end
            2'd1: begin hs = h[1]; dys = dy[1]; hn = h[2]; dl = r_d[1]; dn = r_d[2]; end
            2'd2: begin hs = h[2]; dys = dy[2]; hn = h[3]; dl = r_d[2]; dn = r_d[3]; end
            2'd3: begin hs = h[3]; dys = dy[3]; hn = h[3]; dl = r_d[3]; dn = r_d[3]; end
        endcase
    end

    assign prod_a  = PROD_W'(hn) * PROD_W'(dl);
    assign prod_b  = PROD_W'(hs) * PROD_W'(dn);
    assign quo_sat = (|div_quo[NUM_W-1:SLOPE_W]) ? '1 : div_quo[SLOPE_W-1:0];

    spmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_KICK),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JOB_SEC0;
            r_stale <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_stale) begin
                        r_job   <= JOB_SEC0;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: r_state <= (r_job >= JOB_MEAN0) ? S_ADD : S_KICK;
                S_ADD:  r_state <= S_KICK;
                S_KICK: r_state <= S_WAIT;
                S_WAIT: begin
                    if (div_done) begin
                        if (r_job == JOB_LAST) begin
                            r_state <= S_FIN;
                        end else begin
                            r_job   <= r_job + 4'd1;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_FIN:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            // a write during a rebuild forces another pass
            if (i_cfg_wr) begin
                r_stale <= 1'b1;
            end else if (r_state == S_IDLE) begin
                r_stale <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            if (r_job < JOB_RCP0) begin
                r_num <= NUM_W'({dys, FRAC_BITS'(0)});
                r_den <= hs;
            end else if (r_job < JOB_MEAN0) begin
                r_num <= NUM_W'(1) << RCP_SH;
                r_den <= hs;
            end else begin
                r_num <= NUM_W'(prod_a);
                r_den <= DEN_W'({1'b0, hs} + {1'b0, hn});
            end
        end else if (r_state == S_ADD) begin
            r_num <= r_num + NUM_W'(prod_b);
        end
        if (r_state == S_WAIT && div_done) begin
            if (r_job < JOB_RCP0) begin
                r_d[sel] <= quo_sat;
            end else if (r_job < JOB_MEAN0) begin
                r_recip[sel] <= div_quo[RCP_W-1:0];
            end else begin
                r_mean[sel] <= quo_sat;
            end
        end
        if (r_state == S_FIN) begin
            if (i_cfg.shelf) begin
                // outer knot slopes hold; they are not used
                r_slope[1] <= r_d[1];
                r_slope[2] <= steffen(r_d[1], r_d[2], r_mean[1]);
                r_slope[3] <= r_d[2];
            end else begin
                r_slope[0] <= r_d[0];
                r_slope[1] <= steffen(r_d[0], r_d[1], r_mean[0]);
                r_slope[2] <= steffen(r_d[1], r_d[2], r_mean[1]);
                r_slope[3] <= steffen(r_d[2], r_d[3], r_mean[2]);
                r_slope[4] <= r_d[3];
            end
        end
    end

    assign o_busy      = r_stale || (r_state != S_IDLE);
    assign o_tab.recip = r_recip;
    assign o_tab.slope = r_slope;

endmodule

FILE: design/spmv_eval.sv
// Pipelined Hermite segment evaluator: segment pick, position, basis, weighted sum.
// Depends on spmv_pkg; reads the configuration and the slope table.
module spmv_eval import spmv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [VAL_W-1:0] i_x,
    input  t_cfg             i_cfg,
    input  t_tab             i_tab,
    output logic             o_valid,
    output logic [VAL_W-1:0] o_level
);
    localparam int T_SH  = RCP_SH - 16;
    localparam int NR_W  = VAL_W + RCP_W;
    localparam int HM_W  = VAL_W + SLOPE_W;
    localparam int B_W   = 33;
    localparam int POS_W = 56;

    typedef struct packed {
        logic [VAL_W-1:0]   n;
        logic [VAL_W-1:0]   h;
        logic [RCP_W-1:0]   recip;
        logic [SLOPE_W-1:0] ml;
        logic [SLOPE_W-1:0] mr;
        logic [VAL_W-1:0]   y0;
        logic [VAL_W-1:0]   y1;
        logic               flat;
        logic [VAL_W-1:0]   yflat;
        logic [VAL_W-1:0]   t;
        logic [VAL_W-1:0]   s;
        logic [A_W-1:0]     a0;
        logic [A_W-1:0]     a1;
        logic [33:0]        chk;
        logic [B_W-1:0]     ss;
        logic [B_W-1:0]     tt;
        logic [B_W-1:0]     h00;
        logic [B_W-1:0]     h01;
        logic [B_W-1:0]     h10;
        logic [B_W-1:0]     h11;
        logic [49:0]        py0;
        logic [49:0]        py1;
        logic [53:0]        pa0;
        logic [53:0]        pa1;
        logic [POS_W-1:0]   pos;
    } t_item;

    t_item      n_sa;
    t_item      r_sa, r_sb, r_sc, r_sd, r_se, r_sf, r_sg, r_sh;
    t_item      n_sb, n_sc, n_sd, n_se, n_sf, n_sg, n_sh;
    logic [7:0] r_vld;
    logic       r_out_vld;
    logic [VAL_W-1:0] r_out;

    logic [VAL_W-1:0] xc, x0;
    logic [NR_W-1:0]  prod_nr;
    logic [HM_W-1:0]  prod_a0, prod_a1, a0_sh, a1_sh;
    logic [33:0]      rem;
    logic [VAL_W:0]   t_inc;
    logic [VAL_W-1:0] t_fix;
    logic [50:0]      p00, p01;
    logic [49:0]      p10, p11;
    logic [POS_W-1:0] diff;
    logic [23:0]      rnd;
    logic [VAL_W-1:0] lvl;

    // segment pick
    always_comb begin
        n_sa = '0;
        xc   = (i_x > VAL_W'(ONE)) ? VAL_W'(ONE) : i_x;
        priority if (xc < i_cfg.pin[0]) begin
            x0         = '0;
            n_sa.y0    = '0;
            n_sa.y1    = i_cfg.pout[0];
            n_sa.h     = i_cfg.pin[0];
            n_sa.recip = i_tab.recip[0];
            n_sa.ml    = i_tab.slope[0];
            n_sa.mr    = i_tab.slope[1];
            n_sa.flat  = i_cfg.shelf;
            n_sa.yflat = i_cfg.pout[0];
        end else if (xc < i_cfg.pin[1]) begin
            x0         = i_cfg.pin[0];
            n_sa.y0    = i_cfg.pout[0];
            n_sa.y1    = i_cfg.pout[1];
            n_sa.h     = i_cfg.pin[1] - i_cfg.pin[0];
            n_sa.recip = i_tab.recip[1];
            n_sa.ml    = i_tab.slope[1];
            n_sa.mr    = i_tab.slope[2];
        end else if (xc < i_cfg.pin[2]) begin
            x0         = i_cfg.pin[1];
            n_sa.y0    = i_cfg.pout[1];
            n_sa.y1    = i_cfg.pout[2];
            n_sa.h     = i_cfg.pin[2] - i_cfg.pin[1];
            n_sa.recip = i_tab.recip[2];
            n_sa.ml    = i_tab.slope[2];
            n_sa.mr    = i_tab.slope[3];
        end else begin
            x0         = i_cfg.pin[2];
            n_sa.y0    = i_cfg.pout[2];
            n_sa.y1    = VAL_W'(ONE);
            n_sa.h     = VAL_W'(ONE) - i_cfg.pin[2];
            n_sa.recip = i_tab.recip[3];
            n_sa.ml    = i_tab.slope[3];
            n_sa.mr    = i_tab.slope[4];
            n_sa.flat  = i_cfg.shelf;
            n_sa.yflat = i_cfg.pout[2];
        end
        n_sa.n = xc - x0;
    end

    // position estimate through the reciprocal, slope terms
    assign prod_nr = NR_W'(r_sa.n) * NR_W'(r_sa.recip);
    assign prod_a0 = HM_W'(r_sa.h) * HM_W'(r_sa.ml);
    assign prod_a1 = HM_W'(r_sa.h) * HM_W'(r_sa.mr);
    assign a0_sh   = prod_a0 >> FRAC_BITS;
    assign a1_sh   = prod_a1 >> FRAC_BITS;

    // estimate is low by at most one: correct it with the remainder
    assign rem   = {1'b0, r_sc.n, 16'b0} - r_sc.chk;
    assign t_inc = {1'b0, r_sc.t} + ((rem >= 34'(r_sc.h)) ? (VAL_W+1)'(1) : (VAL_W+1)'(0));
    assign t_fix = (t_inc > (VAL_W+1)'(ONE)) ? VAL_W'(ONE) : t_inc[VAL_W-1:0];

    assign p00 = 51'(18'(ONE) + {r_se.t, 1'b0}) * 51'(r_se.ss);
    assign p01 = 51'(r_se.tt) * 51'(18'(3 * ONE) - {r_se.t, 1'b0});
    assign p10 = 50'(r_se.t) * 50'(r_se.ss);
    assign p11 = 50'(r_se.tt) * 50'(r_se.s);

    // round half up, clamp at zero, saturate to one; flat segments give their shelf level
    assign diff = r_sh.pos - POS_W'(r_sh.pa1) + POS_W'(64'h8000_0000);
    assign rnd  = diff[POS_W-1:32];
    always_comb begin
        priority if (r_sh.flat) begin
            lvl = r_sh.yflat;
        end else if (r_sh.pos <= POS_W'(r_sh.pa1)) begin
            lvl = '0;
        end else if (rnd > 24'(ONE)) begin
            lvl = VAL_W'(ONE);
        end else begin
            lvl = rnd[VAL_W-1:0];
        end
    end

    // next value of each stage: carry the item, fill in what this stage adds
    always_comb begin
        n_sb    = r_sa;
        n_sb.t  = prod_nr[T_SH +: VAL_W];
        n_sb.a0 = (a0_sh > HM_W'(A_MAX)) ? A_W'(A_MAX) : a0_sh[A_W-1:0];
        n_sb.a1 = (a1_sh > HM_W'(A_MAX)) ? A_W'(A_MAX) : a1_sh[A_W-1:0];

        n_sc     = r_sb;
        n_sc.chk = 34'(r_sb.t) * 34'(r_sb.h);

        n_sd   = r_sc;
        n_sd.t = t_fix;
        n_sd.s = VAL_W'(ONE) - t_fix;

        n_se    = r_sd;
        n_se.ss = B_W'(34'(r_sd.s) * 34'(r_sd.s));
        n_se.tt = B_W'(34'(r_sd.t) * 34'(r_sd.t));

        n_sf     = r_se;
        n_sf.h00 = p00[48:16];
        n_sf.h01 = p01[48:16];
        n_sf.h10 = p10[48:16];
        n_sf.h11 = p11[48:16];

        n_sg     = r_sf;
        n_sg.py0 = 50'(r_sf.y0) * 50'(r_sf.h00);
        n_sg.py1 = 50'(r_sf.y1) * 50'(r_sf.h01);
        n_sg.pa0 = 54'(r_sf.a0) * 54'(r_sf.h10);
        n_sg.pa1 = 54'(r_sf.a1) * 54'(r_sf.h11);

        n_sh     = r_sg;
        n_sh.pos = POS_W'(r_sg.py0) + POS_W'(r_sg.py1) + POS_W'(r_sg.pa0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[6:0], i_valid};
            r_out_vld <= r_vld[7];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa  <= n_sa;
        r_sb  <= n_sb;
        r_sc  <= n_sc;
        r_sd  <= n_sd;
        r_se  <= n_se;
        r_sf  <= n_sf;
        r_sg  <= n_sg;
        r_sh  <= n_sh;
        r_out <= lvl;
    end

    assign o_valid = r_out_vld;
    assign o_level = r_out;

endmodule

FILE: design/monotone_spline_velocity_map_unit.sv
// Top level of the monotone spline velocity map: configuration registers,
// slope table builder and evaluation pipeline. Depends on spmv_pkg, spmv_slopes, spmv_eval.
//
//   channel   signals                              transfer
//   ------    ---------------------------------    ---------------------------------
//   item in   start, busy, i_velocity_in           edge with start high, busy low
//   result    o_valid, o_level_out                 every cycle o_valid is high
//   config    i_cfg_we, i_cfg_idx, i_cfg_data      every edge with i_cfg_we high
//
// One item per cycle while busy is low; results come out in order.
// After reset and after each write to a register up to REG_SHELF, busy stays high
// for the slope table rebuild: 11 divisions of the shared bit-serial divider.
// No result can be held off; the pipeline never stalls.
module monotone_spline_velocity_map_unit import spmv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [VAL_W-1:0] i_velocity_in,
    output logic             o_valid,
    output logic [VAL_W-1:0] o_level_out,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0] i_cfg_data
);
    localparam int LAT = 9;

    t_cfg r_cfg;
    t_tab tab;
    logic cfg_wr;
    logic [VAL_W:0] v;

    assign cfg_wr = i_cfg_we && (i_cfg_idx <= REG_SHELF);
    assign v      = {1'b0, i_cfg_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin[0]  <= VAL_W'(EPS);
            r_cfg.pout[0] <= VAL_W'(EPS);
            r_cfg.pin[1]  <= VAL_W'(ONE / 2);
            r_cfg.pout[1] <= VAL_W'(ONE / 2);
            r_cfg.pin[2]  <= VAL_W'(ONE - EPS);
            r_cfg.pout[2] <= VAL_W'(ONE - EPS);
            r_cfg.shelf   <= 1'b1;
        end else if (i_cfg_we) begin
            // clamp each point between its neighbors
            unique case (i_cfg_idx)
                REG_P0_IN:  r_cfg.pin[0] <= clamp_pt(v, (VAL_W+1)'(EPS),
                                {1'b0, r_cfg.pin[1]} - (VAL_W+1)'(EPS));
                REG_P0_OUT: r_cfg.pout[0] <= clamp_pt(v, (VAL_W+1)'(EPS),
                                {1'b0, r_cfg.pout[1]} - (VAL_W+1)'(EPS));
                REG_P1_IN:  r_cfg.pin[1] <= clamp_pt(v,
                                {1'b0, r_cfg.pin[0]} + (VAL_W+1)'(EPS),
                                {1'b0, r_cfg.pin[2]} - (VAL_W+1)'(EPS));
                REG_P1_OUT: r_cfg.pout[1] <= clamp_pt(v,
                                {1'b0, r_cfg.pout[0]} + (VAL_W+1)'(EPS),
                                {1'b0, r_cfg.pout[2]} - (VAL_W+1)'(EPS));
                REG_P2_IN:  r_cfg.pin[2] <= clamp_pt(v,
                                {1'b0, r_cfg.pin[1]} + (VAL_W+1)'(EPS),
                                (VAL_W+1)'(ONE - EPS));
                REG_P2_OUT: r_cfg.pout[2] <= clamp_pt(v,
                                {1'b0, r_cfg.pout[1]} + (VAL_W+1)'(EPS),
                                (VAL_W+1)'(ONE - EPS));
                REG_SHELF:  r_cfg.shelf <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    spmv_slopes u_slopes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cfg_wr (cfg_wr),
        .o_busy   (busy),
        .o_tab    (tab)
    );

    spmv_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_x     (i_velocity_in),
        .i_cfg   (r_cfg),
        .i_tab   (tab),
        .o_valid (o_valid),
        .o_level (o_level_out)
    );

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted item gave no result at the pipeline latency");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level_out <= VAL_W'(ONE)))
        else $error("result level above one");

    a_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> busy)
        else $error("configuration write did not start a slope rebuild");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cfg.pin[0]} + (VAL_W+1)'(EPS) <= {1'b0, r_cfg.pin[1]}) &&
        ({1'b0, r_cfg.pin[1]} + (VAL_W+1)'(EPS) <= {1'b0, r_cfg.pin[2]}))
        else $error("control point inputs lost their ordering");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for monotone_spline_velocity_map_unit: directed table, then random phases.
// Predicts untabled levels with its own fixed-point spline model; depends on spmv_pkg and the RTL.
module tb_top import spmv_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        bit               known;
        logic [VAL_W-1:0] level;
    } t_row;

    localparam int N_PHASES   = 11;
    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE     = 12;

    // register index with no register behind it
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [VAL_W-1:0] i_velocity_in;
    logic             o_valid;
    logic [VAL_W-1:0] o_level_out;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [VAL_W-1:0] i_cfg_data;

    monotone_spline_velocity_map_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_velocity_in(i_velocity_in), .o_valid(o_valid), .o_level_out(o_level_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // spline state kept by the bench
    longint          knot_in[3];
    longint          knot_out[3];
    bit              shelf;
    longint unsigned knot_slope[5];
    bit              slopes_stale;

    logic [VAL_W-1:0] pending_levels[$];
    int               err_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic longint clamp_knot(input longint v, input longint lo, input longint hi);
        longint r;
        r = (v < hi) ? v : hi;
        return (r > lo) ? r : lo;
    endfunction

    function automatic longint unsigned sat_slope(input longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic void apply_reg_write(input logic [IDX_W-1:0] idx,
                                            input logic [VAL_W-1:0] data);
        longint v;
        v = longint'(data);
        if (idx > REG_SHELF)
            return;
        slopes_stale = 1'b1;
        case (idx)
            REG_P0_IN:  knot_in[0]  = clamp_knot(v, EPS, knot_in[1] - EPS);
            REG_P0_OUT: knot_out[0] = clamp_knot(v, EPS, knot_out[1] - EPS);
            REG_P1_IN:  knot_in[1]  = clamp_knot(v, knot_in[0] + EPS, knot_in[2] - EPS);
            REG_P1_OUT: knot_out[1] = clamp_knot(v, knot_out[0] + EPS, knot_out[2] - EPS);
            REG_P2_IN:  knot_in[2]  = clamp_knot(v, knot_in[1] + EPS, ONE - EPS);
            REG_P2_OUT: knot_out[2] = clamp_knot(v, knot_out[1] + EPS, ONE - EPS);
            default:    shelf = data[0];
        endcase
    endfunction

    // Steffen-style knot slopes; shelf mode covers the three inner knots only
    function automatic void rebuild_knot_slopes();
        longint          xs[5];
        longint          ys[5];
        longint unsigned d[4];
        longint unsigned h[4];
        longint unsigned lo, twice, mean;
        int              n, base;
        if (shelf) begin
            n = 3;
            base = 1;
            for (int i = 0; i < 3; i++) begin
                xs[i] = knot_in[i];
                ys[i] = knot_out[i];
            end
        end else begin
            n = 5;
            base = 0;
            xs[0] = 0;
            ys[0] = 0;
            xs[4] = ONE;
            ys[4] = ONE;
            for (int i = 0; i < 3; i++) begin
                xs[i+1] = knot_in[i];
                ys[i+1] = knot_out[i];
            end
        end
        for (int i = 0; i < n - 1; i++) begin
            h[i] = longint'(xs[i+1] - xs[i]);
            d[i] = sat_slope((longint'(ys[i+1] - ys[i]) << FRAC_BITS) / h[i]);
        end
        knot_slope[base] = d[0];
        knot_slope[base+n-1] = d[n-2];
        for (int i = 1; i < n - 1; i++) begin
            lo = (d[i-1] < d[i]) ? d[i-1] : d[i];
            twice = 2 * lo;
            mean = (h[i] * d[i-1] + h[i-1] * d[i]) / (h[i-1] + h[i]);
            knot_slope[base+i] = sat_slope((twice < mean) ? twice : mean);
        end
        slopes_stale = 1'b0;
    endfunction

    function automatic longint unsigned hermite_level(input longint x, input longint x0,
                                                      input longint y0, input longint x1,
                                                      input longint y1,
                                                      input longint unsigned m0,
                                                      input longint unsigned m1);
        longint unsigned dx, t, s, h00, h01, h10, h11, a0, a1, pos, neg, r;
        dx = longint'(x1 - x0);
        t = (longint'(x - x0) << 16) / dx;
        if (t > ONE)
            t = ONE;
        s = ONE - t;
        h00 = ((ONE + 2 * t) * s * s) >> 16;
        h01 = (t * t * (3 * ONE - 2 * t)) >> 16;
        h10 = (t * s * s) >> 16;
        h11 = (t * t * s) >> 16;
        a0 = (dx * m0) >> FRAC_BITS;
        a1 = (dx * m1) >> FRAC_BITS;
        if (a0 > A_MAX)
            a0 = A_MAX;
        if (a1 > A_MAX)
            a1 = A_MAX;
        pos = longint'(y0) * h00 + longint'(y1) * h01 + a0 * h10;
        neg = a1 * h11;
        if (pos <= neg)
            return 0;
        r = (pos - neg + 64'h8000_0000) >> 32;
        return (r > ONE) ? ONE : r;
    endfunction

    function automatic logic [VAL_W-1:0] predict_level(input logic [VAL_W-1:0] vel);
        longint          x;
        longint unsigned y;
        x = longint'(vel);
        if (x > ONE)
            x = ONE;
        if (slopes_stale)
            rebuild_knot_slopes();
        if (x < knot_in[0])
            y = shelf ? knot_out[0] : hermite_level(x, 0, 0, knot_in[0], knot_out[0],
                                                    knot_slope[0], knot_slope[1]);
        else if (x < knot_in[1])
            y = hermite_level(x, knot_in[0], knot_out[0], knot_in[1], knot_out[1],
                              knot_slope[1], knot_slope[2]);
        else if (x < knot_in[2])
            y = hermite_level(x, knot_in[1], knot_out[1], knot_in[2], knot_out[2],
                              knot_slope[2], knot_slope[3]);
        else
            y = shelf ? knot_out[2] : hermite_level(x, knot_in[2], knot_out[2], ONE, ONE,
                                                    knot_slope[3], knot_slope[4]);
        return y[VAL_W-1:0];
    endfunction

    // entered and left at a falling edge; holds start high until the transfer
    task automatic send_velocity(input logic [VAL_W-1:0] vel, input bit known,
                                 input logic [VAL_W-1:0] level);
        logic [VAL_W-1:0] pred;
        start = 1'b1;
        i_velocity_in = vel;
        do @(posedge i_clk); while (busy);
        pred = predict_level(vel);
        pending_levels.push_back(known ? level : pred);
        @(negedge i_clk);
    endtask

    // entered and left at a falling edge, with the pipeline drained
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        start = 1'b0;
        while (pending_levels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        apply_reg_write(idx, data);
        @(negedge i_clk);
        // hold until the slope table rebuild is over
        while (busy)
            @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_reg_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return ONE;
            2: return '1;
            3: return VAL_W'($urandom);
            default: return VAL_W'($urandom_range(0, ONE));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_velocity();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return VAL_W'($urandom);
        if (sel == 1)
            return VAL_W'(knot_in[$urandom_range(0, 2)] + $urandom_range(0, 4) - 2);
        return VAL_W'($urandom_range(0, ONE));
    endfunction

    t_row dir_rows[] = '{
        '{ROW_ITEM, '0, 17'd0,      1'b1, 17'd16},
        '{ROW_ITEM, '0, 17'd15,     1'b1, 17'd16},
        '{ROW_ITEM, '0, 17'd16,     1'b1, 17'd16},
        '{ROW_ITEM, '0, 17'd17,     1'b0, '0},
        '{ROW_ITEM, '0, 17'd12345,  1'b0, '0},
        '{ROW_ITEM, '0, 17'd32767,  1'b0, '0},
        '{ROW_ITEM, '0, 17'd32768,  1'b1, 17'd32768},
        '{ROW_ITEM, '0, 17'd50000,  1'b0, '0},
        '{ROW_ITEM, '0, 17'd65519,  1'b0, '0},
        '{ROW_ITEM, '0, 17'd65520,  1'b1, 17'd65520},
        '{ROW_ITEM, '0, 17'd65536,  1'b1, 17'd65520},
        '{ROW_ITEM, '0, 17'd131071, 1'b1, 17'd65520},
        '{ROW_CFG,  REG_SHELF,  17'd0,      1'b0, '0},
        '{ROW_CFG,  REG_P0_IN,  17'd0,      1'b0, '0},
        '{ROW_CFG,  REG_P0_OUT, 17'd0,      1'b0, '0},
        '{ROW_CFG,  REG_P2_IN,  17'd131071, 1'b0, '0},
        '{ROW_CFG,  REG_P2_OUT, 17'd131071, 1'b0, '0},
        '{ROW_CFG,  REG_NONE,   17'd131071, 1'b0, '0},
        '{ROW_ITEM, '0, 17'd0,      1'b1, 17'd0},
        '{ROW_ITEM, '0, 17'd8,      1'b0, '0},
        '{ROW_ITEM, '0, 17'd40000,  1'b0, '0},
        '{ROW_ITEM, '0, 17'd65528,  1'b0, '0},
        '{ROW_ITEM, '0, 17'd65536,  1'b1, 17'd65536},
        '{ROW_ITEM, '0, 17'd131071, 1'b1, 17'd65536}
    };

    always @(posedge i_clk) begin
        logic [VAL_W-1:0] want;
        if (i_rst_n && o_valid) begin
            if (pending_levels.size() == 0) begin
                report_mismatch($sformatf("unexpected level %0d", o_level_out));
            end else begin
                want = pending_levels.pop_front();
                if (o_level_out !== want)
                    report_mismatch($sformatf("level %0d, want %0d", o_level_out, want));
            end
        end
    end

    initial begin
        int unsigned order[7];
        int unsigned j, tmp;
        bit          quiet;
        err_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_velocity_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        knot_in = '{EPS, 32768, ONE - EPS};
        knot_out = '{EPS, 32768, ONE - EPS};
        shelf = 1'b1;
        knot_slope = '{0, 0, 0, 0, 0};
        rebuild_knot_slopes();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_reg(dir_rows[r].idx, dir_rows[r].value);
            else
                send_velocity(dir_rows[r].value, dir_rows[r].known, dir_rows[r].level);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            for (int i = 0; i < 7; i++)
                order[i] = i;
            for (int i = 6; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < 7; i++)
                if (p < 2 || $urandom_range(0, 3) != 0)
                    write_reg(IDX_W'(order[i]), pick_reg_value());
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_NONE, VAL_W'($urandom));
            quiet = (p == N_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (!quiet && $urandom_range(0, 3) == 0) begin
                    start = 1'b0;
                    repeat ($urandom_range(1, 7)) @(negedge i_clk);
                end
                send_velocity(pick_velocity(), 1'b0, '0);
            end
        end
        start = 1'b0;

        while (pending_levels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
